// File: hdl/byte_escape_dump_encoder_top_assert.svh
// Assertion macros used by the byte escape dump encoder RTL.
`ifndef BYTE_ESCAPE_DUMP_ENCODER_TOP_ASSERT_SVH
`define BYTE_ESCAPE_DUMP_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BEDE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bede assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BEDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bede assertion failed");

`endif

// File: hdl/bede_pkg.sv
// Package: types, codes and character tables of the byte escape dump encoder.
`default_nettype none

package bede_pkg;

  // dump_mode codes
  localparam logic [1:0] MODE_HEX  = 2'd0;
  localparam logic [1:0] MODE_VOCT = 2'd1;
  localparam logic [1:0] MODE_VHEX = 2'd2;
  localparam logic [1:0] MODE_STR  = 2'd3;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DUMP_MODE = 2'd0;
  localparam logic [1:0] REG_SEP_CHAR  = 2'd1;
  localparam logic [1:0] REG_REPL_CHAR = 2'd2;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] RST_DUMP_MODE = MODE_VOCT;
  localparam logic [7:0] RST_SEP_CHAR  = 8'h20;
  localparam logic [7:0] RST_REPL_CHAR = 8'h2E;

  localparam logic [7:0] ESC_CHAR        = 8'h5C;
  localparam logic [7:0] DEFAULT_REPLACE = 8'h2E;
  localparam logic [7:0] ZERO_CHAR       = 8'h30;

  // rendering kinds decided in the classify stage
  localparam logic [2:0] KIND_HEX  = 3'd0; // two hex digits + optional separator
  localparam logic [2:0] KIND_ESC2 = 3'd1; // backslash + letter
  localparam logic [2:0] KIND_PASS = 3'd2; // byte as is
  localparam logic [2:0] KIND_REPL = 3'd3; // replacement char
  localparam logic [2:0] KIND_OCT  = 3'd4; // backslash + three octal digits
  localparam logic [2:0] KIND_XESC = 3'd5; // backslash + two hex digits

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       buffer_end;
  } char_t;

  typedef struct packed {
    logic [1:0] dump_mode;
    logic [7:0] separator_char;
    logic [7:0] replace_char;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [2:0] kind;
  } cls_t;

  typedef struct packed {
    logic [3:0][7:0] chars;  // chars[0] goes out first
    logic [1:0]      cnt;    // character count minus one
    logic            last_byte;
  } rnd_t;

  function automatic logic is_readable(input logic [7:0] c);
    is_readable = c inside {[8'h21:8'h7E]};
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      hex_digit = 8'h30 + {4'h0, n};
    end else begin
      hex_digit = 8'h37 + {4'h0, n};
    end
  endfunction

  // second character of a two-character escape
  function automatic logic [7:0] esc_letter(input logic [7:0] b);
    case (b)
      8'h07:    esc_letter = "a";
      8'h08:    esc_letter = "b";
      8'h09:    esc_letter = "t";
      8'h0A:    esc_letter = "n";
      8'h0B:    esc_letter = "v";
      8'h0C:    esc_letter = "f";
      8'h0D:    esc_letter = "r";
      ESC_CHAR: esc_letter = ESC_CHAR;
      default:  esc_letter = ZERO_CHAR;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: hdl/bede_classify.sv
// Stage 1: classifies each byte into a rendering kind.
`default_nettype none

module bede_classify (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       dump_mode,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire bede_pkg::byte_t  up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output bede_pkg::cls_t        dn_data
);

  logic [7:0] b;
  logic       common;
  logic       readable;
  logic [2:0] kind_next;

  assign b        = up_data.data_byte;
  assign readable = bede_pkg::is_readable(b);
  assign common   = (b == bede_pkg::ESC_CHAR) || (b inside {[8'h07:8'h0D]}) ||
                    (b == 8'h00);

  always_comb begin
    case (dump_mode)
      bede_pkg::MODE_HEX: begin
        kind_next = bede_pkg::KIND_HEX;
      end
      bede_pkg::MODE_STR: begin
        if (common) kind_next = bede_pkg::KIND_ESC2;
        else if (readable) kind_next = bede_pkg::KIND_PASS;
        else kind_next = bede_pkg::KIND_REPL;
      end
      default: begin
        if (common) kind_next = bede_pkg::KIND_ESC2;
        else if (readable) kind_next = bede_pkg::KIND_PASS;
        else if (dump_mode == bede_pkg::MODE_VHEX) kind_next = bede_pkg::KIND_XESC;
        else kind_next = bede_pkg::KIND_OCT;
      end
    endcase
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data.data_byte <= up_data.data_byte;
      dn_data.last_byte <= up_data.last_byte;
      dn_data.kind      <= kind_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bede_render.sv
// Stage 2: builds the character group and count for one classified byte.
`default_nettype none

module bede_render (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       separator_char,
  input  wire logic [7:0]       replace_char,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire bede_pkg::cls_t   up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output bede_pkg::rnd_t        dn_data
);

  logic [7:0]      b;
  logic [7:0]      hi_dig;
  logic [7:0]      lo_dig;
  logic [7:0]      repl;
  logic [3:0][7:0] chars_next;
  logic [1:0]      cnt_next;

  assign b      = up_data.data_byte;
  assign hi_dig = bede_pkg::hex_digit(b[7:4]);
  assign lo_dig = bede_pkg::hex_digit(b[3:0]);
  // an unreadable replacement falls back to '.'
  assign repl   = bede_pkg::is_readable(replace_char) ? replace_char :
                  bede_pkg::DEFAULT_REPLACE;

  always_comb begin
    chars_next = '0;
    cnt_next   = 2'd0;
    case (up_data.kind)
      bede_pkg::KIND_HEX: begin
        chars_next[0] = hi_dig;
        chars_next[1] = lo_dig;
        chars_next[2] = separator_char;
        cnt_next      = (separator_char != 8'h00) ? 2'd2 : 2'd1;
      end
      bede_pkg::KIND_ESC2: begin
        chars_next[0] = bede_pkg::ESC_CHAR;
        chars_next[1] = bede_pkg::esc_letter(b);
        cnt_next      = 2'd1;
      end
      bede_pkg::KIND_PASS: begin
        chars_next[0] = b;
      end
      bede_pkg::KIND_REPL: begin
        chars_next[0] = repl;
      end
      bede_pkg::KIND_OCT: begin
        chars_next[0] = bede_pkg::ESC_CHAR;
        chars_next[1] = bede_pkg::hex_digit({2'b00, b[7:6]});
        chars_next[2] = bede_pkg::hex_digit({1'b0, b[5:3]});
        chars_next[3] = bede_pkg::hex_digit({1'b0, b[2:0]});
        cnt_next      = 2'd3;
      end
      bede_pkg::KIND_XESC: begin
        chars_next[0] = bede_pkg::ESC_CHAR;
        chars_next[1] = hi_dig;
        chars_next[2] = lo_dig;
        cnt_next      = 2'd2;
      end
      default: begin
        chars_next[0] = b;
      end
    endcase
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data.chars     <= chars_next;
      dn_data.cnt       <= cnt_next;
      dn_data.last_byte <= up_data.last_byte;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bede_serial.sv
// Stage 3: sends a character group one character a cycle into the output register, unless the output stalls.
`default_nettype none

`include "byte_escape_dump_encoder_top_assert.svh"

module bede_serial (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire bede_pkg::rnd_t   up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output bede_pkg::char_t       dn_data
);

  logic            grp_valid;
  logic [3:0][7:0] grp_chars;
  logic [1:0]      grp_cnt;
  logic [1:0]      grp_idx;
  logic            grp_last;
  logic            out_load;
  logic            grp_done;
  logic            at_end;

  assign at_end   = (grp_idx == grp_cnt);
  assign out_load = grp_valid && (!dn_valid || dn_ready);
  assign grp_done = out_load && at_end;
  assign up_ready = !grp_valid || grp_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (up_ready) begin
      grp_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      grp_chars <= up_data.chars;
      grp_cnt   <= up_data.cnt;
      grp_last  <= up_data.last_byte;
      grp_idx   <= 2'd0;
    end else if (out_load) begin
      grp_idx <= grp_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (out_load) begin
      dn_valid <= 1'b1;
    end else if (dn_ready) begin
      dn_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dn_data.out_char   <= grp_chars[grp_idx];
      dn_data.run_last   <= at_end;
      dn_data.buffer_end <= at_end && grp_last;
    end
  end

  `BEDE_ASSERT_NOW(a_idx_in_range, grp_valid, grp_idx <= grp_cnt)
  `BEDE_ASSERT_NEXT(a_group_holds, out_load && !at_end, grp_valid)
  `BEDE_ASSERT_NOW(a_end_on_last, dn_valid && dn_data.buffer_end, dn_data.run_last)

endmodule

`default_nettype wire

// File: hdl/byte_escape_dump_encoder_top.sv
// Top level of the byte escape dump encoder: register file and three-stage pipeline.
//
// Usage: raw bytes enter on the byte channel (byte_valid/byte_ready, payload
// byte_data with data_byte and last_byte). Text leaves on the char channel
// (char_valid/char_ready, payload char_data), one ASCII character per
// transaction; run_last marks the last character of a byte, buffer_end the
// last character of a byte flagged last_byte.
// Pipeline: classify stage, render stage, serializer feeding an output
// register. The first character of a byte passes through the classify,
// render, group and output registers before it is presented.
// Serializer: a byte producing N characters (1 to 4) holds the serializer
// while it loads them one by one into the output register, so the
// single-character output port limits the byte rate. The next byte is taken
// in the same cycle the previous byte's last character is loaded out.
// Stall: when char_ready is low the output register holds and the stages
// behind it fill and then deassert byte_ready; nothing is dropped or repeated.
// Reset (rst, synchronous): clears all stage valid bits and loads the
// registers with dump_mode 1, separator_char 0x20, replace_char 0x2E.
// Registers are to be written through the APB port only while the pipeline is empty; the block does not enforce this.
`default_nettype none

module byte_escape_dump_encoder_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // byte channel
  input  wire logic                          byte_valid,
  output logic                               byte_ready,
  input  wire bede_pkg::byte_t               byte_data,
  // char channel
  output logic                               char_valid,
  input  wire logic                          char_ready,
  output bede_pkg::char_t                    char_data,
  // APB register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bede_pkg::APB_AW-1:0]   paddr,
  input  wire logic [bede_pkg::APB_DW-1:0]   pwdata,
  output logic [bede_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  bede_pkg::cfg_t cfg;
  logic           wr_en;
  logic [1:0]     reg_idx;

  logic           cls_valid;
  logic           cls_ready;
  bede_pkg::cls_t cls_data;
  logic           rnd_valid;
  logic           rnd_ready;
  bede_pkg::rnd_t rnd_data;

  // ---- register file ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dump_mode      <= bede_pkg::RST_DUMP_MODE;
      cfg.separator_char <= bede_pkg::RST_SEP_CHAR;
      cfg.replace_char   <= bede_pkg::RST_REPL_CHAR;
    end else if (wr_en) begin
      case (reg_idx)
        bede_pkg::REG_DUMP_MODE: cfg.dump_mode      <= pwdata[1:0];
        bede_pkg::REG_SEP_CHAR:  cfg.separator_char <= pwdata[7:0];
        bede_pkg::REG_REPL_CHAR: cfg.replace_char   <= pwdata[7:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bede_pkg::REG_DUMP_MODE: prdata = {{(bede_pkg::APB_DW-2){1'b0}}, cfg.dump_mode};
      bede_pkg::REG_SEP_CHAR:  prdata = {{(bede_pkg::APB_DW-8){1'b0}}, cfg.separator_char};
      bede_pkg::REG_REPL_CHAR: prdata = {{(bede_pkg::APB_DW-8){1'b0}}, cfg.replace_char};
      default:                 prdata = '0;
    endcase
  end

  // ---- pipeline ----
  // stage 1: byte -> rendering kind
  bede_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .dump_mode (cfg.dump_mode),
    .up_valid  (byte_valid),
    .up_ready  (byte_ready),
    .up_data   (byte_data),
    .dn_valid  (cls_valid),
    .dn_ready  (cls_ready),
    .dn_data   (cls_data)
  );

  // stage 2: kind -> up to four characters plus count
  bede_render u_render (
    .clk            (clk),
    .rst            (rst),
    .separator_char (cfg.separator_char),
    .replace_char   (cfg.replace_char),
    .up_valid       (cls_valid),
    .up_ready       (cls_ready),
    .up_data        (cls_data),
    .dn_valid       (rnd_valid),
    .dn_ready       (rnd_ready),
    .dn_data        (rnd_data)
  );

  // stage 3: one character per cycle into the output register, unless char_ready stalls it
  bede_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .up_valid (rnd_valid),
    .up_ready (rnd_ready),
    .up_data  (rnd_data),
    .dn_valid (char_valid),
    .dn_ready (char_ready),
    .dn_data  (char_data)
  );

endmodule

`default_nettype wire

// File: dv/byte_escape_dump_encoder_top_test.sv
// Testbench for the byte escape dump encoder: directed and random bytes checked per character.
`timescale 1ns / 100ps

module byte_escape_dump_encoder_top_test;

  // Runaway guard, set far beyond the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  // index with no register behind it
  localparam int          UNMAPPED_REG = 3;

  // Expected text per accepted byte, plus the register shadow it is rendered with.
  class char_scoreboard;
    logic [1:0]      mode;
    logic [7:0]      sep;
    logic [7:0]      repl;
    bede_pkg::char_t expected_chars[$];
    int              errors;

    function new();
      mode   = bede_pkg::RST_DUMP_MODE;
      sep    = bede_pkg::RST_SEP_CHAR;
      repl   = bede_pkg::RST_REPL_CHAR;
      errors = 0;
    endfunction

    // Register write as the block sees it; unknown indexes are dropped.
    function void set_reg(int idx, logic [31:0] value);
      case (idx)
        bede_pkg::REG_DUMP_MODE: mode = value[1:0];
        bede_pkg::REG_SEP_CHAR:  sep  = value[7:0];
        bede_pkg::REG_REPL_CHAR: repl = value[7:0];
        default: ;
      endcase
    endfunction

    function bit printable(logic [7:0] c);
      return c inside {[8'h21:8'h7E]};
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return 8'h41 + 8'(n) - 8'd10;
    endfunction

    // Backslash, the C control letters and NUL all render as backslash + one char.
    function bit two_char_escape(logic [7:0] d, output logic [7:0] second);
      second = 8'h00;
      case (d)
        bede_pkg::ESC_CHAR: second = bede_pkg::ESC_CHAR;
        8'h00:    second = "0";
        8'h07:    second = "a";
        8'h08:    second = "b";
        8'h09:    second = "t";
        8'h0A:    second = "n";
        8'h0B:    second = "v";
        8'h0C:    second = "f";
        8'h0D:    second = "r";
        default:  return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void note_byte(bede_pkg::byte_t b);
      logic [7:0]      txt[$];
      logic [7:0]      d;
      logic [7:0]      ch2;
      logic [7:0]      sub;
      bede_pkg::char_t c;
      d = b.data_byte;
      case (mode)
        bede_pkg::MODE_HEX: begin
          txt = {hex_char(d[7:4]), hex_char(d[3:0])};
          // separator follows every pair, the final byte's included
          if (sep != 8'h00) txt = {txt, sep};
        end
        bede_pkg::MODE_STR: begin
          if (two_char_escape(d, ch2)) begin
            txt = {bede_pkg::ESC_CHAR, ch2};
          end else begin
            sub = printable(repl) ? repl : bede_pkg::DEFAULT_REPLACE;
            txt = {printable(d) ? d : sub};
          end
        end
        default: begin
          if (two_char_escape(d, ch2)) begin
            txt = {bede_pkg::ESC_CHAR, ch2};
          end else if (printable(d)) begin
            txt = {d};
          end else if (mode == bede_pkg::MODE_VHEX) begin
            txt = {bede_pkg::ESC_CHAR, hex_char(d[7:4]), hex_char(d[3:0])};
          end else begin
            txt = {bede_pkg::ESC_CHAR, hex_char({2'b00, d[7:6]}), hex_char({1'b0, d[5:3]}),
                   hex_char({1'b0, d[2:0]})};
          end
        end
      endcase
      foreach (txt[i]) begin
        c.out_char   = txt[i];
        c.run_last   = (i == txt.size() - 1);
        c.buffer_end = c.run_last & b.last_byte;
        expected_chars = {expected_chars, c};
      end
    endfunction

    function void check_char(bede_pkg::char_t got);
      bede_pkg::char_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected char: char=%h run_last=%b buffer_end=%b",
                   got.out_char, got.run_last, got.buffer_end);
        return;
      end
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char || got.run_last !== want.run_last ||
          got.buffer_end !== want.buffer_end) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"char mismatch: expected char=%h run_last=%b buffer_end=%b,",
                    " got char=%h run_last=%b buffer_end=%b"},
                   want.out_char, want.run_last, want.buffer_end,
                   got.out_char, got.run_last, got.buffer_end);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------- signals
  logic                          clk        = 1'b0;
  logic                          rst        = 1'b1;
  logic                          byte_valid = 1'b0;
  logic                          byte_ready;
  bede_pkg::byte_t               byte_data  = '0;
  logic                          char_valid;
  logic                          char_ready = 1'b0;
  bede_pkg::char_t               char_data;
  logic                          psel       = 1'b0;
  logic                          penable    = 1'b0;
  logic                          pwrite     = 1'b0;
  logic [bede_pkg::APB_AW-1:0]   paddr      = '0;
  logic [bede_pkg::APB_DW-1:0]   pwdata     = '0;
  logic [bede_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  char_scoreboard      sb;
  bede_pkg::byte_t     stim_q[$];
  int unsigned         send_idle_pct = 0;   // chance per cycle the sender holds off
  int unsigned         stall_pct     = 0;   // chance per cycle the receiver stalls
  int unsigned         cycles        = 0;

  byte_escape_dump_encoder_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: ready is redrawn every cycle from the current stall rate.
  always @(posedge clk) begin
    char_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: values read here are the ones sampled at this edge, so every
  // accepted transaction on either channel is seen exactly once.
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && byte_ready) sb.note_byte(byte_data);
      if (char_valid && char_ready) sb.check_char(char_data);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tasks
  // Setup then access phase; pready is tied high but still honored.
  task automatic apb_write(input int idx, input logic [7:0] field);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bede_pkg::APB_AW'(4 * idx);
    // junk in the upper bits: the block keeps only the field width
    pwdata  <= ($urandom() & 32'hFFFF_FF00) | 32'(field);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, {24'h0, field});
  endtask

  // Waits until every predicted char has left the block. Always waits on the
  // clock before the first check so the monitor has noted the byte accepted just now.
  task automatic wait_drained();
    do @(posedge clk); while (sb.expected_chars.size() != 0);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [7:0] sep,
                            input logic [7:0] repl);
    apb_write(bede_pkg::REG_REPL_CHAR, repl);
    apb_write(bede_pkg::REG_DUMP_MODE, {6'h0, mode});
    apb_write(bede_pkg::REG_SEP_CHAR, sep);
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 52; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 52; end
      default: begin send_idle_pct = 12; stall_pct = 12; end
    endcase
  endtask

  // Drives stim_q out on the byte channel. Valid stays up between
  // back-to-back transactions; gaps and the occasional full drain happen
  // only right after an acceptance.
  task automatic send_bytes();
    foreach (stim_q[i]) begin
      byte_valid <= 1'b1;
      byte_data  <= stim_q[i];
      do @(posedge clk); while (!byte_ready);
      if ($urandom_range(29) == 0) begin
        byte_valid <= 1'b0;
        wait_drained();
      end else if ($urandom_range(99) < send_idle_pct) begin
        byte_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
      end
    end
    byte_valid <= 1'b0;
    stim_q.delete();
  endtask

  function automatic bede_pkg::byte_t make_byte(input logic [7:0] d, input logic lst);
    bede_pkg::byte_t b;
    b.data_byte = d;
    b.last_byte = lst;
    return b;
  endfunction

  // A quarter of random bytes come from the escape boundaries.
  function automatic bede_pkg::byte_t random_byte();
    logic [7:0] d;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(11))
        0:  d = 8'h00;
        1:  d = 8'h06;
        2:  d = 8'h07;
        3:  d = 8'h0D;
        4:  d = 8'h0E;
        5:  d = bede_pkg::ESC_CHAR;
        6:  d = 8'h20;
        7:  d = 8'h21;
        8:  d = 8'h7E;
        9:  d = 8'h7F;
        10: d = 8'h80;
        default: d = 8'hFF;
      endcase
    end else begin
      d = 8'($urandom_range(255));
    end
    return make_byte(d, $urandom_range(3) == 0);
  endfunction

  // ---------------------------------------------------------------- main
  initial begin
    logic [1:0] mode;
    logic [7:0] sep;
    logic [7:0] repl;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset settings (octal value escape): every escape class
    // and both edges of the readable range.
    set_idling(0);
    stim_q = {make_byte(8'h00, 1'b0), make_byte(8'h07, 1'b0), make_byte(8'h0D, 1'b0),
              make_byte(bede_pkg::ESC_CHAR, 1'b0), make_byte(8'h20, 1'b0),
              make_byte(8'h21, 1'b0), make_byte(8'h7E, 1'b0), make_byte(8'h7F, 1'b1),
              make_byte(8'hFF, 1'b0), make_byte(8'h0E, 1'b1)};
    send_bytes();
    wait_drained();

    // Directed, hex value escape.
    set_config(bede_pkg::MODE_VHEX, 8'h20, 8'h2E);
    stim_q = {make_byte(8'hFF, 1'b0), make_byte(8'h7F, 1'b0), make_byte(8'h1F, 1'b0),
              make_byte(8'h00, 1'b1), make_byte(8'h41, 1'b1)};
    send_bytes();
    wait_drained();

    // Directed, hex dump without separator; a write to an unmapped index
    // must not disturb anything.
    set_config(bede_pkg::MODE_HEX, 8'h00, 8'h2E);
    apb_write(UNMAPPED_REG, 8'hFF);
    stim_q = {make_byte(8'h00, 1'b0), make_byte(8'hFF, 1'b1), make_byte(8'hA5, 1'b0)};
    send_bytes();
    wait_drained();

    // Directed, string escape with an unreadable replacement (space).
    set_config(bede_pkg::MODE_STR, 8'h20, 8'h20);
    stim_q = {make_byte(8'h01, 1'b0), make_byte(8'h80, 1'b0),
              make_byte(bede_pkg::ESC_CHAR, 1'b0), make_byte(8'h0A, 1'b0),
              make_byte(8'h41, 1'b1), make_byte(8'h20, 1'b1)};
    send_bytes();
    wait_drained();

    // Random phases: each writes every register, extremes among the settings,
    // and cycles through the four idling patterns.
    for (int ph = 0; ph < 12; ph++) begin
      mode = 2'($urandom_range(3));
      sep  = 8'($urandom_range(255));
      repl = 8'($urandom_range(255));
      case (ph)
        0:  begin mode = bede_pkg::MODE_HEX;  sep = 8'h20; end
        1:  begin mode = bede_pkg::MODE_HEX;  sep = 8'h00; end
        2:  begin mode = bede_pkg::MODE_HEX;  sep = 8'hFF; end
        3:  mode = bede_pkg::MODE_VOCT;
        4:  mode = bede_pkg::MODE_VHEX;
        5:  begin mode = bede_pkg::MODE_STR;  repl = 8'h00; end
        6:  begin mode = bede_pkg::MODE_STR;  repl = 8'hFF; end
        7:  begin mode = bede_pkg::MODE_STR;  repl = 8'h21; end
        8:  begin mode = bede_pkg::MODE_STR;  repl = 8'h7E; end
        9:  begin mode = bede_pkg::MODE_STR;  repl = 8'h7F; end
        10: mode = bede_pkg::MODE_STR;
        default: ;
      endcase
      set_config(mode, sep, repl);
      set_idling(ph);
      repeat (11) stim_q = {stim_q, random_byte()};
      send_bytes();
      wait_drained();
    end

    // Tail: give stray chars a chance to show up, then judge.
    repeat (20) @(posedge clk);
    #1;
    if (sb.expected_chars.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
